[src/cbb_pkg.sv]
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared widths, codes and bundle types of the connected bipartition search.
// ----------------------------------------------------------------------------
package cbb_pkg;

    localparam int MAX_NODES_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int NODE_W   = 4;
    localparam int WEIGHT_W = 10;
    localparam int DIFF_W   = 14;
    localparam int COUNT_W  = 5;

    localparam logic [DIFF_W-1:0]  DIFF_ONES     = {DIFF_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_RST_VAL = COUNT_W'(2);

    // Beat kinds carried on the input tuser
    localparam logic [MODE_W-1:0] MODE_LOAD_WEIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_EDGE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START       = 2'd2;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
    } cbb_edge_t;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [DIFF_W-1:0] diff;
    } cbb_result_t;

endpackage

[src/cbb_ram.sv]
// ----------------------------------------------------------------------------
// cbb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/cbb_adj.sv]
// ----------------------------------------------------------------------------
// cbb_adj
// Undirected adjacency rows: symmetric edge insert, one row read per cycle.
// ----------------------------------------------------------------------------
module cbb_adj #(
    parameter int MAX_NODES = cbb_pkg::MAX_NODES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cbb_pkg::cbb_edge_t           edge_wr,
    input  logic [$clog2(MAX_NODES)-1:0] row_idx,
    output logic [MAX_NODES-1:0]         row
);
    import cbb_pkg::*;

    logic [MAX_NODES-1:0] rows_reg  [MAX_NODES];
    logic [MAX_NODES-1:0] rows_next [MAX_NODES];

    always_comb
    begin
        for (int r = 0; r < MAX_NODES; r++)
        begin
            for (int c = 0; c < MAX_NODES; c++)
            begin
                rows_next[r][c] = rows_reg[r][c]
                    | (edge_wr.en && ((32'(edge_wr.a) == r && 32'(edge_wr.b) == c)
                                   || (32'(edge_wr.b) == r && 32'(edge_wr.a) == c)));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_NODES; r++)
            begin
                rows_reg[r] <= '0;
            end
        end
        else
        begin
            rows_reg <= rows_next;
        end
    end

    assign row = rows_reg[row_idx];

endmodule

[src/cbb_search.sv]
// ----------------------------------------------------------------------------
// cbb_search
// Subset sequencer with one shared sweep unit: per subset it walks the node
// index, growing both reach sets in place and summing both sides' weights.
// ----------------------------------------------------------------------------
module cbb_search #(
    parameter int MAX_NODES = cbb_pkg::MAX_NODES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [cbb_pkg::COUNT_W-1:0]       node_count,
    output logic                              busy,
    output logic [$clog2(MAX_NODES)-1:0]      idx,
    input  logic [MAX_NODES-1:0]              row,
    input  logic [cbb_pkg::WEIGHT_W-1:0]      rd_data,
    output cbb_pkg::cbb_result_t              res,
    input  logic                              res_ready
);
    import cbb_pkg::*;

    localparam int IW    = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int SUM_W = $clog2(MAX_NODES * ((1 << WEIGHT_W) - 1) + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_INIT  = 6'b000010,
        ST_SWEEP = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_EVAL  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [MAX_NODES-1:0] active_reg, active_next;
    logic [MAX_NODES-1:0] half_reg, half_next;
    logic [MAX_NODES-1:0] m_reg, m_next;
    logic [MAX_NODES-1:0] reach_a_reg, reach_a_next;
    logic [MAX_NODES-1:0] reach_b_reg, reach_b_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        last_idx_reg, last_idx_next;
    logic                 first_reg, first_next;
    logic                 changed_reg, changed_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic                 rd_side_reg, rd_side_next;
    logic [SUM_W-1:0]     sa_reg, sa_next;
    logic [SUM_W-1:0]     sb_reg, sb_next;
    logic [DIFF_W-1:0]    best_reg, best_next;
    logic                 found_reg, found_next;

    logic [CNT_W-1:0]     n_sat;
    logic [MAX_NODES-1:0] other;
    logic [MAX_NODES-1:0] grow_a, grow_b;
    logic                 grow_changed;
    logic [SUM_W-1:0]     diff_raw;
    logic [DIFF_W-1:0]    diff_sat;
    logic                 split_ok;

    assign n_sat = (32'(node_count) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count);
    assign other = active_reg & ~m_reg;

    // in-place frontier step for the node at idx
    assign grow_a = reach_a_reg[idx_reg] ? (reach_a_reg | (row & m_reg)) : reach_a_reg;
    assign grow_b = reach_b_reg[idx_reg] ? (reach_b_reg | (row & other)) : reach_b_reg;
    assign grow_changed = (grow_a != reach_a_reg) || (grow_b != reach_b_reg);

    assign diff_raw = (sa_reg > sb_reg) ? (sa_reg - sb_reg) : (sb_reg - sa_reg);
    assign diff_sat = (32'(diff_raw) > 32'(DIFF_ONES)) ? DIFF_ONES : DIFF_W'(diff_raw);
    assign split_ok = (reach_a_reg == m_reg) && (reach_b_reg == other);

    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        half_next     = half_reg;
        m_next        = m_reg;
        reach_a_next  = reach_a_reg;
        reach_b_next  = reach_b_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        first_next    = first_reg;
        changed_next  = changed_reg;
        rd_valid_next = 1'b0;
        rd_side_next  = m_reg[idx_reg];
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        best_next     = best_reg;
        found_next    = found_reg;

        // weight read issued last cycle lands now
        if (rd_valid_reg)
        begin
            if (rd_side_reg)
            begin
                sa_next = sa_reg + SUM_W'(rd_data);
            end
            else
            begin
                sb_next = sb_reg + SUM_W'(rd_data);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    best_next  = DIFF_ONES;
                    found_next = 1'b0;
                    for (int i = 0; i < MAX_NODES; i++)
                    begin
                        active_next[i] = (i < 32'(n_sat));
                        half_next[i]   = (i == 32'(n_sat) - 1);
                    end
                    last_idx_next = IW'(32'(n_sat) - 1);
                    m_next        = MAX_NODES'(1);
                    state_next    = (32'(n_sat) < 2) ? ST_DONE : ST_INIT;
                end
            end
            ST_INIT:
            begin
                reach_a_next = m_reg & (~m_reg + MAX_NODES'(1));
                reach_b_next = other & (~other + MAX_NODES'(1));
                idx_next     = '0;
                first_next   = 1'b1;
                changed_next = 1'b0;
                sa_next      = '0;
                sb_next      = '0;
                state_next   = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                reach_a_next  = grow_a;
                reach_b_next  = grow_b;
                rd_valid_next = first_reg;
                if (idx_reg == last_idx_reg)
                begin
                    if (changed_reg || grow_changed)
                    begin
                        idx_next     = '0;
                        first_next   = 1'b0;
                        changed_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    idx_next     = idx_reg + IW'(1);
                    changed_next = changed_reg || grow_changed;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (split_ok && (!found_reg || diff_sat < best_reg))
                begin
                    best_next = diff_sat;
                end
                found_next = found_reg || split_ok;
                if ((m_reg + MAX_NODES'(1)) == half_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    m_next     = m_reg + MAX_NODES'(1);
                    state_next = ST_INIT;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            best_reg     <= DIFF_ONES;
            m_reg        <= '0;
            sa_reg       <= '0;
            sb_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
            best_reg     <= best_next;
            m_reg        <= m_next;
            sa_reg       <= sa_next;
            sb_reg       <= sb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        active_reg   <= active_next;
        half_reg     <= half_next;
        reach_a_reg  <= reach_a_next;
        reach_b_reg  <= reach_b_next;
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        first_reg    <= first_next;
        changed_reg  <= changed_next;
        rd_side_reg  <= rd_side_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign idx       = idx_reg;
    assign res.valid = (state_reg == ST_DONE);
    assign res.found = found_reg;
    assign res.diff  = found_reg ? best_reg : '0;

endmodule

[src/connected_bipartition_balance_top.sv]
// ----------------------------------------------------------------------------
// connected_bipartition_balance_top
// Balanced connected bipartition search over a small weighted graph.
// ----------------------------------------------------------------------------
// Load beats (node weight, undirected edge) are taken one per cycle while the
// search is idle and give no output. A start beat splits the first node_count
// nodes every way into two non-empty sides, keeps the splits where both sides
// are connected and returns the least weight difference with a found flag.
// With fewer than two nodes the search goes straight to done and m_tvalid
// rises once the output register is free. Otherwise each of the 2^(n-1)-1
// candidate sides passes init, 1..n-1 index sweeps of the shared frontier unit
// until both reach sets stop growing, drain and eval; each sweep visits one
// adjacency row per cycle, the first also one weight. s_tready is low from the
// start beat until the result is handed to the output register.
// ----------------------------------------------------------------------------
module connected_bipartition_balance_top #(
    parameter int MAX_NODES = cbb_pkg::MAX_NODES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [cbb_pkg::COUNT_W-1:0] cfg_wdata,   // node_count
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,     // node_a[3:0], node_b[7:4], weight[17:8]
    input  logic [cbb_pkg::MODE_W-1:0]  s_tuser,     // mode[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,     // min_difference[13:0]
    output logic                        m_tuser      // found[0]
);
    import cbb_pkg::*;

    localparam int IW = $clog2(MAX_NODES);

    logic [COUNT_W-1:0]  node_count_reg;
    logic                m_tvalid_reg;
    logic [DIFF_W-1:0]   m_diff_reg;
    logic                m_found_reg;

    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
    logic                beat;
    logic                a_ok, b_ok;
    logic                weight_we;
    logic                start;
    logic                busy;
    logic                res_ready;
    logic [IW-1:0]       idx;
    logic [MAX_NODES-1:0] row;
    logic [WEIGHT_W-1:0] rd_data;
    cbb_edge_t           edge_wr;
    cbb_result_t         res;

    assign node_a = s_tdata[3:0];
    assign node_b = s_tdata[7:4];
    assign weight = s_tdata[17:8];

    assign s_tready = !busy;
    assign beat     = s_tvalid && s_tready;
    assign a_ok     = 32'(node_a) < MAX_NODES;
    assign b_ok     = 32'(node_b) < MAX_NODES;

    assign weight_we  = beat && (s_tuser == MODE_LOAD_WEIGHT) && a_ok;
    assign edge_wr.en = beat && (s_tuser == MODE_ADD_EDGE) && a_ok && b_ok;
    assign edge_wr.a  = node_a;
    assign edge_wr.b  = node_b;
    assign start      = beat && (s_tuser == MODE_START);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= COUNT_RST_VAL;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    cbb_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_NODES)
    ) u_weight_ram (
        .clk   (clk),
        .we    (weight_we),
        .waddr (IW'(node_a)),
        .wdata (weight),
        .raddr (idx),
        .rdata (rd_data)
    );

    cbb_adj #(
        .MAX_NODES (MAX_NODES)
    ) u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .edge_wr (edge_wr),
        .row_idx (idx),
        .row     (row)
    );

    cbb_search #(
        .MAX_NODES (MAX_NODES)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .node_count (node_count_reg),
        .busy       (busy),
        .idx        (idx),
        .row        (row),
        .rd_data    (rd_data),
        .res        (res),
        .res_ready  (res_ready)
    );

    // output stage
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            m_diff_reg  <= res.diff;
            m_found_reg <= res.found;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_diff_reg};
    assign m_tuser  = m_found_reg;

endmodule

[tb/connected_bipartition_balance_top_tb.sv]
// ----------------------------------------------------------------------------
// connected_bipartition_balance_top_tb
// Self-checking bench for the balanced connected bipartition search.
// ----------------------------------------------------------------------------
// Drives weight, edge, start and reserved beats into the stream slave port and
// checks every result beat against a bit-accurate software copy of the graph
// search held in the bench. Directed tests come first: default node count,
// the saturated 16-node search on an edgeless graph, node counts 0 and 1,
// self edges, edges to inactive nodes and reserved beats. A random phase
// follows with random node counts, random gaps on the sender and random
// backpressure on the result port. Node count is only changed while idle.
// ----------------------------------------------------------------------------
module connected_bipartition_balance_top_tb;

    import cbb_pkg::*;

    localparam int NODES      = MAX_NODES_DEF;
    localparam int BEAT_GOAL  = 1800;
    localparam int IDLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYC = 8;

    // mode 3 carries no meaning; the block drops it
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    typedef struct packed {
        logic              found;
        logic [DIFF_W-1:0] diff;
    } split_expect_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [COUNT_W-1:0]  cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;
    logic [MODE_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;
    logic                m_tuser;

    // predictor state
    logic [NODES-1:0]    graph_adj [NODES];
    logic [WEIGHT_W-1:0] node_wt   [NODES];
    logic [COUNT_W-1:0]  node_limit;

    split_expect_t       pending_splits [$];

    bit tx_eager;
    bit rx_eager;
    int fail_count;
    int idle_cycles;
    int beats_sent;
    int ignored_sent;
    int searches_checked;
    int splits_found;
    int widest_count;

    connected_bipartition_balance_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit side_connected(input logic [NODES-1:0] set);
        logic [NODES-1:0] reach;
        logic [NODES-1:0] grown;
        int               i;
        if (set == '0)
            return 1'b0;
        reach = set & (~set + 1'b1);
        forever
        begin
            grown = reach;
            for (i = 0; i < NODES; i++)
                if (reach[i])
                    grown |= graph_adj[i];
            grown &= set;
            if (grown == reach)
                break;
            reach = grown;
        end
        return reach == set;
    endfunction

    function automatic int side_weight(input logic [NODES-1:0] set);
        int sum;
        int i;
        sum = 0;
        for (i = 0; i < NODES; i++)
            if (set[i])
                sum += node_wt[i];
        return sum;
    endfunction

    // Splits are enumerated by the side that leaves out the highest active node.
    function automatic split_expect_t predict_split();
        split_expect_t    res;
        int               n;
        int               total;
        int               sa;
        int               d;
        int               best;
        int               m;
        int               half;
        logic [NODES-1:0] active;
        logic [NODES-1:0] side;
        res  = '0;
        best = DIFF_ONES;
        n    = (node_limit > NODES) ? NODES : node_limit;
        if (n >= 2)
        begin
            active = NODES'((32'd1 << n) - 1);
            total  = side_weight(active);
            half   = 1 << (n - 1);
            for (m = 1; m < half; m++)
            begin
                side = NODES'(m);
                if (!side_connected(side) || !side_connected(active & ~side))
                    continue;
                sa = side_weight(side);
                d  = (2 * sa > total) ? 2 * sa - total : total - 2 * sa;
                if (d > DIFF_ONES)
                    d = DIFF_ONES;
                if (!res.found || d < best)
                    best = d;
                res.found = 1'b1;
            end
            if (res.found)
                res.diff = DIFF_W'(best);
        end
        return res;
    endfunction

    function automatic void track_beat(input logic [MODE_W-1:0]   mode,
                                       input logic [NODE_W-1:0]   a,
                                       input logic [NODE_W-1:0]   b,
                                       input logic [WEIGHT_W-1:0] w);
        case (mode)
            MODE_LOAD_WEIGHT: node_wt[a] = w;
            MODE_ADD_EDGE:
            begin
                graph_adj[a][b] = 1'b1;
                graph_adj[b][a] = 1'b1;
            end
            MODE_START:       pending_splits.insert(pending_splits.size(), predict_split());
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_beat(input logic [MODE_W-1:0]   mode,
                             input logic [NODE_W-1:0]   a,
                             input logic [NODE_W-1:0]   b,
                             input logic [WEIGHT_W-1:0] w);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, w, b, a};
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        track_beat(mode, a, b, w);
        if (mode == MODE_RESERVED)
            ignored_sent++;
        else
            beats_sent++;
    endtask

    task automatic load_weight(input int node, input int w);
        push_beat(MODE_LOAD_WEIGHT, NODE_W'(node), NODE_W'($urandom_range(0, 15)),
                  WEIGHT_W'(w));
    endtask

    task automatic add_link(input int a, input int b);
        push_beat(MODE_ADD_EDGE, NODE_W'(a), NODE_W'(b),
                  WEIGHT_W'($urandom_range(0, 1023)));
    endtask

    task automatic start_search();
        push_beat(MODE_START, NODE_W'($urandom_range(0, 15)),
                  NODE_W'($urandom_range(0, 15)), WEIGHT_W'($urandom_range(0, 1023)));
    endtask

    // Drop valid and wait for the block to go quiet.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_splits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Caller must have settled first.
    task automatic set_node_count(input int count);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_W'(count);
        @(negedge clk);
        cfg_we    <= 1'b0;
        node_limit = COUNT_W'(count);
        if (count > widest_count)
            widest_count = count;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every weight is written up front so no search reads an unwritten one.
    task automatic test_weights_at_default_count();
        int i;
        load_weight(0, 0);
        load_weight(1, 1023);
        for (i = 2; i < NODES; i++)
            load_weight(i, $urandom_range(0, 1023));
        start_search();
        settle();
    endtask

    // 31 saturates to 16 nodes; edgeless graph keeps the sweep count low.
    task automatic test_widest_search();
        set_node_count(16);
        load_weight(15, 1023);
        settle();
        set_node_count(31);
        start_search();
        settle();
    endtask

    task automatic test_degenerate_counts();
        set_node_count(0);
        start_search();
        settle();
        set_node_count(1);
        start_search();
        settle();
    endtask

    task automatic test_edge_corners();
        set_node_count(2);
        add_link(0, 1);
        start_search();
        settle();
        set_node_count(3);
        add_link(2, 2);             // self loop leaves node 2 isolated
        start_search();
        add_link(2, 15);            // far end is inactive
        add_link(15, 0);
        start_search();
        push_beat(MODE_RESERVED, NODE_W'($urandom_range(0, 15)),
                  NODE_W'($urandom_range(0, 15)), WEIGHT_W'($urandom_range(0, 1023)));
        add_link(1, 2);
        start_search();
        settle();
    endtask

    task automatic test_random_traffic();
        int sel;
        int len;
        int pick;
        while (beats_sent + ignored_sent < BEAT_GOAL)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                set_node_count($urandom_range(0, 1));
            else if (sel < 3)
                set_node_count(8);
            else
                set_node_count($urandom_range(2, 7));
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            len = $urandom_range(20, 60);
            repeat (len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    load_weight($urandom_range(0, 15), $urandom_range(0, 1023));
                else if (pick < 53)
                    add_link($urandom_range(0, 15), $urandom_range(0, 15));
                else if (pick < 88)
                    start_search();
                else
                    push_beat(MODE_RESERVED, NODE_W'($urandom_range(0, 15)),
                              NODE_W'($urandom_range(0, 15)),
                              WEIGHT_W'($urandom_range(0, 1023)));
            end
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    initial
    begin
        int hold;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_eager)
                m_tready <= 1'b1;
            else if (m_tvalid && !m_tready)
            begin
                hold = $urandom_range(0, 12);
                repeat (hold) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (m_tready)
                m_tready <= 1'b0;
        end
    end

    initial
    begin
        split_expect_t exp;
        bit            moved;
        forever
        begin
            @(posedge clk);
            moved = 1'b0;
            if (rst_n)
            begin
                if (s_tvalid && s_tready)
                    moved = 1'b1;
                if (m_tvalid && m_tready)
                begin
                    moved = 1'b1;
                    if (pending_splits.size() == 0)
                        note_failure($sformatf("unexpected result beat: diff=%0d found=%0b",
                                               m_tdata[DIFF_W-1:0], m_tuser));
                    else
                    begin
                        exp = pending_splits.pop_front();
                        searches_checked++;
                        if (exp.found)
                            splits_found++;
                        if (m_tdata[DIFF_W-1:0] !== exp.diff || m_tuser !== exp.found)
                            note_failure($sformatf(
                                "result mismatch: expected diff=%0d found=%0b, got diff=%0d found=%0b",
                                exp.diff, exp.found, m_tdata[DIFF_W-1:0], m_tuser));
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog; the idle limit is sized to outlast the widest search.
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        tx_eager  = 1'b0;
        rx_eager  = 1'b0;
        fail_count       = 0;
        idle_cycles      = 0;
        beats_sent       = 0;
        ignored_sent     = 0;
        searches_checked = 0;
        splits_found     = 0;
        widest_count     = COUNT_RST_VAL;
        node_limit       = COUNT_RST_VAL;
        for (i = 0; i < NODES; i++)
        begin
            graph_adj[i] = '0;
            node_wt[i]   = '0;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_weights_at_default_count();
        test_widest_search();
        test_degenerate_counts();
        test_edge_corners();
        test_random_traffic();

        settle();
        repeat (20) @(posedge clk);
        if (pending_splits.size() != 0)
            note_failure($sformatf("%0d searches never answered", pending_splits.size()));

        $display("sent %0d weight/edge/start beats and %0d reserved beats, node counts 0..%0d",
                 beats_sent, ignored_sent, widest_count);
        $display("checked %0d search results, %0d with a balanced split, %0d failures",
                 searches_checked, splits_found, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
